/* rtl/epmd_pkg.sv */
// ----------------------------------------------------------------------------
// epmd_pkg: shared types and constants of the encoder position motor drive
// Holds the register map, item codes, controller commands and status, and the
// fixed widths of the iterative divider.
// ----------------------------------------------------------------------------
package epmd_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int DIVIDEND_W = 24;
  localparam int DIVISOR_W  = 9;
  localparam int STEP_W     = $clog2(DIVIDEND_W);

  localparam logic [7:0]           SLOW_PERCENT  = 8'd40;
  localparam logic [7:0]           KICK_PERCENT  = 8'd99;
  localparam logic [DIVISOR_W-1:0] PERCENT_SCALE = 9'd100;
  localparam logic signed [15:0]   FULL_TURN     = 16'sd360;

  localparam logic [6:0]         MIN_SPEED_RESET     = 7'd0;
  localparam logic [6:0]         MAX_SPEED_RESET     = 7'd100;
  localparam logic [15:0]        PERIOD_COUNT_RESET  = 16'd65535;
  localparam logic signed [15:0] MIN_ANGLE_RESET     = -16'sd360;
  localparam logic signed [15:0] MAX_ANGLE_RESET     = 16'sd360;
  localparam logic [8:0]         DEG_PER_PULSE_RESET = 9'd1;
  localparam logic [14:0]        DEFAULT_COUNT_RESET = 15'd16384;
  localparam logic signed [15:0] INITIAL_ANGLE_RESET = 16'sd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_SPEED     = 3'd0,
    REG_MAX_SPEED     = 3'd1,
    REG_PERIOD_COUNT  = 3'd2,
    REG_MIN_ANGLE     = 3'd3,
    REG_MAX_ANGLE     = 3'd4,
    REG_DEG_PER_PULSE = 3'd5,
    REG_DEFAULT_COUNT = 3'd6,
    REG_INITIAL_ANGLE = 3'd7
  } epmd_reg_t;

  typedef enum logic [2:0] {
    MODE_SPEED  = 3'd0,
    MODE_STOP   = 3'd1,
    MODE_MOVE   = 3'd2,
    MODE_SAMPLE = 3'd3,
    MODE_TICK   = 3'd4,
    MODE_INIT   = 3'd5
  } epmd_mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_ABOVE = 2'd2,
    ST_BUSY  = 2'd3
  } epmd_status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_KICK = 2'd1,
    PH_SLOW = 2'd2
  } epmd_phase_t;

  typedef enum logic [1:0] {
    PCT_COMMAND = 2'd0,
    PCT_SLOW    = 2'd1,
    PCT_KICK    = 2'd2
  } epmd_pct_t;

  typedef enum logic [1:0] {
    DIV_PULSES = 2'd0,
    DIV_LOW    = 2'd1,
    DIV_HIGH   = 2'd2,
    DIV_MAP    = 2'd3
  } epmd_div_sel_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_STOP      = 3'd1,
    ACT_DRIVE_LOW = 3'd2,
    ACT_DIV_WRITE = 3'd3,
    ACT_MOVE_CW   = 3'd4,
    ACT_MOVE_CCW  = 3'd5,
    ACT_TO_SLOW   = 3'd6,
    ACT_SAMPLE    = 3'd7
  } epmd_act_t;

  typedef enum logic [2:0] {
    S_IDLE      = 3'd0,
    S_DECODE    = 3'd1,
    S_DRV_CHECK = 3'd2,
    S_DIV_START = 3'd3,
    S_DIV_WAIT  = 3'd4,
    S_FINISH    = 3'd5
  } epmd_state_t;

  typedef struct packed {
    logic          capture;
    logic          set_status;
    epmd_status_t  status;
    logic          set_pct;
    epmd_pct_t     pct_sel;
    logic          prep;
    epmd_div_sel_t div_sel;
    logic          div_start;
    epmd_act_t     act;
    logic          load_out;
  } epmd_cmd_t;

  typedef struct packed {
    epmd_mode_t    mode;
    logic          busy;
    logic          kick;
    logic          slow;
    logic          ang_above;
    logic          ang_below;
    logic          ang_zero;
    logic          ang_full_cw;
    logic          ang_full_ccw;
    logic          pct_below;
    logic          pct_above;
    logic          drv_external;
    logic          map_flat;
    logic          div_done;
    epmd_div_sel_t div_sel;
    logic          out_free;
  } epmd_stat_t;

endpackage

/* rtl/epmd_ifs.sv */
// ----------------------------------------------------------------------------
// epmd_ifs: item channels of the encoder position motor drive
// A command channel and a result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface epmd_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [7:0]         speed;
  logic               direction;
  logic signed [15:0] move_angle;
  logic [15:0]        encoder_count;

  modport source (output valid, mode, speed, direction, move_angle, encoder_count,
                  input ready);
  modport sink (input valid, mode, speed, direction, move_angle, encoder_count,
                output ready);
endinterface

interface epmd_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        compare_a;
  logic [15:0]        compare_b;
  logic [1:0]         status;
  logic               moving;
  logic signed [15:0] shaft_angle;
  logic [15:0]        current_count;

  modport source (output valid, compare_a, compare_b, status, moving, shaft_angle,
                  current_count, input ready);
  modport sink (input valid, compare_a, compare_b, status, moving, shaft_angle,
                current_count, output ready);
endinterface

/* rtl/epmd_div.sv */
// ----------------------------------------------------------------------------
// epmd_div: restoring divider, one quotient bit per cycle
// Divides an unsigned dividend by a non-zero unsigned divisor and flags the
// end of the run with a single-cycle done pulse; the quotient then holds.
// ----------------------------------------------------------------------------
module epmd_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [epmd_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [epmd_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output logic [epmd_pkg::DIVIDEND_W-1:0] quotient
);
  import epmd_pkg::*;

  logic                  running;
  logic [STEP_W-1:0]     step;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign shifted = {rem, quotient[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIVIDEND_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (running) begin
      rem      <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

/* rtl/epmd_datapath.sv */
// ----------------------------------------------------------------------------
// epmd_datapath: registers and arithmetic of the encoder position motor drive
// Holds the configuration, the captured item, the move state, the compare
// limits, the operand stage in front of the divider and the result register.
// ----------------------------------------------------------------------------
module epmd_datapath #(
  parameter int COUNT_BITS = epmd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [epmd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [epmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [2:0]                       in_mode,
  input  logic [7:0]                       in_speed,
  input  logic                             in_direction,
  input  logic signed [15:0]               in_move_angle,
  input  logic [15:0]                      in_encoder_count,
  input  epmd_pkg::epmd_cmd_t              cmd,
  output epmd_pkg::epmd_stat_t             stat,
  epmd_out_if.source                       result
);
  import epmd_pkg::*;

  localparam logic [15:0] SAMPLE_MASK =
    (COUNT_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << COUNT_BITS) - 64'd1);

  logic [6:0]         speed_floor;
  logic [6:0]         speed_ceiling;
  logic [15:0]        period_count;
  logic signed [15:0] angle_floor;
  logic signed [15:0] angle_ceiling;
  logic [8:0]         deg_per_pulse;
  logic [14:0]        default_count;
  logic signed [15:0] initial_angle;

  epmd_mode_t         item_mode;
  logic [7:0]         item_speed;
  logic               item_dir;
  logic signed [15:0] item_angle;
  logic [15:0]        item_sample;

  epmd_phase_t        move_phase;
  logic               move_direction;
  logic signed [17:0] target_count;
  logic [15:0]        last_count;
  logic [15:0]        angle_total;
  logic [15:0]        pending_angle;
  logic [15:0]        drive_a;
  logic [15:0]        drive_b;
  logic [15:0]        low_compare;
  logic [15:0]        high_compare;
  epmd_status_t       status;

  epmd_pct_t          drv_sel;
  logic [7:0]         drv_pct;
  logic               drv_dir;

  epmd_div_sel_t           div_sel;
  logic [DIVIDEND_W-1:0]   dividend;
  logic [DIVISOR_W-1:0]    divisor;
  logic                    div_done;
  logic [DIVIDEND_W-1:0]   quotient;

  logic [15:0]        mul_a;
  logic [6:0]         mul_b;
  logic [22:0]        product;
  logic signed [16:0] angle_ext;
  logic [16:0]        angle_mag;
  logic [15:0]        sat_quotient;
  logic [15:0]        map_value;
  logic [16:0]        pulses;
  logic               sample_done;
  logic               out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_floor   <= MIN_SPEED_RESET;
      speed_ceiling <= MAX_SPEED_RESET;
      period_count  <= PERIOD_COUNT_RESET;
      angle_floor   <= MIN_ANGLE_RESET;
      angle_ceiling <= MAX_ANGLE_RESET;
      deg_per_pulse <= DEG_PER_PULSE_RESET;
      default_count <= DEFAULT_COUNT_RESET;
      initial_angle <= INITIAL_ANGLE_RESET;
    end else if (cfg_write) begin
      case (epmd_reg_t'(cfg_index))
        REG_MIN_SPEED:     speed_floor   <= cfg_data[6:0];
        REG_MAX_SPEED:     speed_ceiling <= cfg_data[6:0];
        REG_PERIOD_COUNT:  period_count  <= cfg_data;
        REG_MIN_ANGLE:     angle_floor   <= $signed(cfg_data);
        REG_MAX_ANGLE:     angle_ceiling <= $signed(cfg_data);
        REG_DEG_PER_PULSE: deg_per_pulse <= cfg_data[8:0];
        REG_DEFAULT_COUNT: default_count <= cfg_data[14:0];
        REG_INITIAL_ANGLE: initial_angle <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode   <= epmd_mode_t'(in_mode);
      item_speed  <= in_speed;
      item_dir    <= in_direction;
      item_angle  <= in_move_angle;
      item_sample <= in_encoder_count & SAMPLE_MASK;
    end
  end

  always_comb begin
    case (drv_sel)
      PCT_COMMAND: drv_pct = item_speed;
      PCT_SLOW:    drv_pct = SLOW_PERCENT;
      PCT_KICK:    drv_pct = KICK_PERCENT;
      default:     drv_pct = item_speed;
    endcase
  end

  assign drv_dir = (drv_sel == PCT_COMMAND) ? item_dir : move_direction;

  assign angle_ext = {item_angle[15], item_angle};
  assign angle_mag = angle_ext[16] ? 17'(-angle_ext) : 17'(angle_ext);

  always_comb begin
    case (cmd.div_sel)
      DIV_LOW: begin
        mul_a = period_count;
        mul_b = speed_floor;
      end
      DIV_HIGH: begin
        mul_a = period_count;
        mul_b = speed_ceiling;
      end
      default: begin
        mul_a = high_compare - low_compare;
        mul_b = drv_pct[6:0] - speed_floor;
      end
    endcase
  end

  assign product = 23'(mul_a) * 23'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_sel <= DIV_PULSES;
      drv_sel <= PCT_COMMAND;
    end else begin
      if (cmd.prep) begin
        div_sel <= cmd.div_sel;
      end
      if (cmd.set_pct) begin
        drv_sel <= cmd.pct_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      case (cmd.div_sel)
        DIV_PULSES: begin
          dividend <= DIVIDEND_W'(angle_mag);
          divisor  <= (deg_per_pulse == '0) ? DIVISOR_W'(1) : deg_per_pulse;
        end
        DIV_LOW, DIV_HIGH: begin
          dividend <= DIVIDEND_W'(product);
          divisor  <= PERCENT_SCALE;
        end
        default: begin
          dividend <= DIVIDEND_W'(product);
          divisor  <= DIVISOR_W'(speed_ceiling - speed_floor);
        end
      endcase
    end
  end

  epmd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sat_quotient = (quotient[DIVIDEND_W-1:16] != '0) ? 16'hFFFF : quotient[15:0];
  assign map_value    = low_compare + quotient[15:0];
  assign pulses       = quotient[16:0];
  assign sample_done  = move_direction ? ($signed({2'b00, item_sample}) < target_count)
                                       : ($signed({2'b00, item_sample}) > target_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      move_phase     <= PH_IDLE;
      move_direction <= 1'b0;
      target_count   <= '0;
      last_count     <= '0;
      angle_total    <= '0;
      pending_angle  <= '0;
      drive_a        <= '0;
      drive_b        <= '0;
      low_compare    <= '0;
      high_compare   <= '0;
    end else begin
      case (cmd.act)
        ACT_STOP: begin
          drive_a <= '0;
          drive_b <= '0;
        end
        ACT_DRIVE_LOW: begin
          drive_a <= drv_dir ? 16'd0 : low_compare;
          drive_b <= drv_dir ? low_compare : 16'd0;
        end
        ACT_DIV_WRITE: begin
          case (div_sel)
            DIV_PULSES: begin
              move_direction <= item_angle[15];
              target_count   <= item_angle[15]
                                ? $signed({2'b00, last_count}) - $signed({1'b0, pulses})
                                : $signed({2'b00, last_count}) + $signed({1'b0, pulses});
              pending_angle  <= item_angle;
              move_phase     <= PH_KICK;
            end
            DIV_LOW: begin
              low_compare <= sat_quotient;
            end
            DIV_HIGH: begin
              high_compare <= sat_quotient;
              angle_total  <= initial_angle;
              last_count   <= {1'b0, default_count};
            end
            default: begin
              drive_a <= drv_dir ? 16'd0 : map_value;
              drive_b <= drv_dir ? map_value : 16'd0;
            end
          endcase
        end
        ACT_MOVE_CW: begin
          move_direction <= 1'b0;
          target_count   <= $signed({2'b00, default_count, 1'b0});
          pending_angle  <= item_angle;
          move_phase     <= PH_SLOW;
        end
        ACT_MOVE_CCW: begin
          move_direction <= 1'b1;
          target_count   <= '0;
          pending_angle  <= item_angle;
          move_phase     <= PH_SLOW;
        end
        ACT_TO_SLOW: begin
          move_phase <= PH_SLOW;
        end
        ACT_SAMPLE: begin
          last_count <= item_sample;
          if (sample_done) begin
            drive_a     <= '0;
            drive_b     <= '0;
            angle_total <= angle_total + pending_angle;
            move_phase  <= PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= ST_OK;
    end else if (cmd.capture) begin
      status <= ST_OK;
    end else if (cmd.set_status) begin
      status <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.compare_a     <= drive_a;
      result.compare_b     <= drive_b;
      result.status        <= status;
      result.moving        <= (move_phase != PH_IDLE);
      result.shaft_angle   <= $signed(angle_total);
      result.current_count <= last_count;
    end
  end

  assign result.valid = out_valid;

  always_comb begin
    stat.mode         = item_mode;
    stat.busy         = (move_phase != PH_IDLE);
    stat.kick         = (move_phase == PH_KICK);
    stat.slow         = (move_phase == PH_SLOW);
    stat.ang_above    = item_angle > angle_ceiling;
    stat.ang_below    = item_angle < angle_floor;
    stat.ang_zero     = (item_angle == 16'sd0);
    stat.ang_full_cw  = (item_angle == FULL_TURN);
    stat.ang_full_ccw = (item_angle == -FULL_TURN);
    stat.pct_below    = drv_pct < {1'b0, speed_floor};
    stat.pct_above    = drv_pct > {1'b0, speed_ceiling};
    stat.drv_external = (drv_sel == PCT_COMMAND);
    stat.map_flat     = (speed_ceiling == speed_floor) || (high_compare < low_compare);
    stat.div_done     = div_done;
    stat.div_sel      = div_sel;
    stat.out_free     = !out_valid || result.ready;
  end

endmodule

/* rtl/epmd_ctrl.sv */
// ----------------------------------------------------------------------------
// epmd_ctrl: sequencing state machine of the encoder position motor drive
// Decodes each item, orders the range checks, divider runs and register
// updates in the datapath, and hands the result to the output register.
// ----------------------------------------------------------------------------
module epmd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  epmd_pkg::epmd_stat_t stat,
  output epmd_pkg::epmd_cmd_t  cmd
);
  import epmd_pkg::*;

  epmd_state_t state;
  epmd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.mode)
          MODE_SPEED: state_next = stat.busy ? S_FINISH : S_DRV_CHECK;
          MODE_MOVE: begin
            if (stat.busy || stat.ang_above || stat.ang_below || stat.ang_zero) begin
              state_next = S_FINISH;
            end else if (stat.ang_full_cw || stat.ang_full_ccw) begin
              state_next = S_DRV_CHECK;
            end else begin
              state_next = S_DIV_START;
            end
          end
          MODE_TICK: state_next = stat.kick ? S_DRV_CHECK : S_FINISH;
          MODE_INIT: state_next = stat.busy ? S_FINISH : S_DIV_START;
          default:   state_next = S_FINISH;
        endcase
      end
      S_DRV_CHECK: begin
        if (stat.pct_below || stat.pct_above || stat.map_flat) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_DIV_START;
        end
      end
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          case (stat.div_sel)
            DIV_PULSES: state_next = S_DRV_CHECK;
            DIV_LOW:    state_next = S_DIV_START;
            default:    state_next = S_FINISH;
          endcase
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE: begin
        case (stat.mode)
          MODE_SPEED: begin
            if (stat.busy) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BUSY;
            end else begin
              cmd.set_pct = 1'b1;
              cmd.pct_sel = PCT_COMMAND;
            end
          end
          MODE_STOP: begin
            if (stat.busy) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BUSY;
            end else begin
              cmd.act = ACT_STOP;
            end
          end
          MODE_MOVE: begin
            if (stat.busy) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BUSY;
            end else if (stat.ang_above) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_ABOVE;
            end else if (stat.ang_below) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UNDER;
            end else if (stat.ang_zero) begin
              cmd.act = ACT_NONE;
            end else if (stat.ang_full_cw) begin
              cmd.act     = ACT_MOVE_CW;
              cmd.set_pct = 1'b1;
              cmd.pct_sel = PCT_SLOW;
            end else if (stat.ang_full_ccw) begin
              cmd.act     = ACT_MOVE_CCW;
              cmd.set_pct = 1'b1;
              cmd.pct_sel = PCT_SLOW;
            end else begin
              cmd.prep    = 1'b1;
              cmd.div_sel = DIV_PULSES;
            end
          end
          MODE_SAMPLE: begin
            if (stat.slow) begin
              cmd.act = ACT_SAMPLE;
            end
          end
          MODE_TICK: begin
            if (stat.kick) begin
              cmd.act     = ACT_TO_SLOW;
              cmd.set_pct = 1'b1;
              cmd.pct_sel = PCT_SLOW;
            end
          end
          MODE_INIT: begin
            if (stat.busy) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BUSY;
            end else begin
              cmd.prep    = 1'b1;
              cmd.div_sel = DIV_LOW;
            end
          end
          default: ;
        endcase
      end
      S_DRV_CHECK: begin
        if (stat.pct_below) begin
          cmd.set_status = stat.drv_external;
          cmd.status     = ST_UNDER;
        end else if (stat.pct_above) begin
          cmd.set_status = stat.drv_external;
          cmd.status     = ST_ABOVE;
        end else if (stat.map_flat) begin
          cmd.act = ACT_DRIVE_LOW;
        end else begin
          cmd.prep    = 1'b1;
          cmd.div_sel = DIV_MAP;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.act = ACT_DIV_WRITE;
          case (stat.div_sel)
            DIV_PULSES: begin
              cmd.set_pct = 1'b1;
              cmd.pct_sel = PCT_KICK;
            end
            DIV_LOW: begin
              cmd.prep    = 1'b1;
              cmd.div_sel = DIV_HIGH;
            end
            default: ;
          endcase
        end
      end
      S_FINISH: begin
        cmd.load_out = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/encoder_position_motor_drive.sv */
// ----------------------------------------------------------------------------
// encoder_position_motor_drive: H-bridge PWM compare drive with encoder moves
// Speed commands, stops, angle moves, encoder samples, millisecond ticks and
// initialisation each produce one result item with both compare values.
//
// The request channel carries one command item; the result channel returns
// one item for every command, in order. Limits and scaling are to be set
// through the write port only while no command is in flight; the block
// itself does not enforce this. A command is taken when the block is idle.
// A speed command, a tick or a full-turn move that maps a percentage runs
// the shared 24-step divider once, an initialisation runs it twice, and any
// other angle move runs it once for the pulse count and once more if it then
// maps a percentage.
// The next command is accepted in the cycle after the result is registered,
// so with a ready receiver an item occupies the block up to that point.
// Reset loads the register defaults, stops the bridge, ends any move and
// empties the result register. While the receiver stalls, one finished result
// waits in the output register; a further result holds the block until it
// can be written there.
// ----------------------------------------------------------------------------
module encoder_position_motor_drive #(
  parameter int COUNT_BITS = epmd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [epmd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [epmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  epmd_in_if.sink                          request,
  epmd_out_if.source                       result
);
  import epmd_pkg::*;

  epmd_cmd_t  cmd;
  epmd_stat_t stat;
  logic       in_ready;

  assign request.ready = in_ready;

  epmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  epmd_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_mode          (request.mode),
    .in_speed         (request.speed),
    .in_direction     (request.direction),
    .in_move_angle    (request.move_angle),
    .in_encoder_count (request.encoder_count),
    .cmd              (cmd),
    .stat             (stat),
    .result           (result)
  );

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the encoder position motor drive
// Drives command items through the request channel and predicts every result
// item from a behavioural model of the bridge drive, comparing field by field.
// Runs a directed opening, then angle moves, speed commands and noise under
// several register settings and three patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import epmd_pkg::*;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;

  typedef struct packed {
    logic [15:0]        cmp_a;
    logic [15:0]        cmp_b;
    epmd_status_t       status;
    logic               moving;
    logic signed [15:0] angle;
    logic [15:0]        count;
  } drive_result_t;

  class drive_tracker;
    bit [6:0]         speed_floor, speed_ceiling;
    bit [15:0]        period;
    bit signed [15:0] min_ang, max_ang, init_ang;
    bit [8:0]         dpp;
    bit [14:0]        dflt_count;
    epmd_phase_t      phase;
    bit               ccw;
    longint           target;
    bit [15:0]        count, cmp_a, cmp_b, low_cmp, high_cmp;
    bit signed [15:0] angle_sum, angle_pending;
    drive_result_t    expected_drives[$];
    int               errors;

    function new();
      speed_floor = MIN_SPEED_RESET;
      speed_ceiling = MAX_SPEED_RESET;
      period = PERIOD_COUNT_RESET;
      min_ang = MIN_ANGLE_RESET;
      max_ang = MAX_ANGLE_RESET;
      dpp = DEG_PER_PULSE_RESET;
      dflt_count = DEFAULT_COUNT_RESET;
      init_ang = INITIAL_ANGLE_RESET;
      phase = PH_IDLE;
      ccw = 1'b0;
      target = 0;
      count = '0;
      cmp_a = '0;
      cmp_b = '0;
      low_cmp = '0;
      high_cmp = '0;
      angle_sum = '0;
      angle_pending = '0;
      errors = 0;
    endfunction

    function void write_reg(epmd_reg_t idx, bit [15:0] v);
      case (idx)
        REG_MIN_SPEED:     speed_floor = v[6:0];
        REG_MAX_SPEED:     speed_ceiling = v[6:0];
        REG_PERIOD_COUNT:  period = v;
        REG_MIN_ANGLE:     min_ang = v;
        REG_MAX_ANGLE:     max_ang = v;
        REG_DEG_PER_PULSE: dpp = v[8:0];
        REG_DEFAULT_COUNT: dflt_count = v[14:0];
        REG_INITIAL_ANGLE: init_ang = v;
        default: ;
      endcase
    endfunction

    function bit [15:0] scale_period(bit [6:0] pct);
      int unsigned v;
      v = period;
      v = (v * pct) / 100;
      return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function epmd_status_t set_drive(int unsigned pct, bit ccw_side);
      int unsigned lo, hi, mn, mx, val;
      lo = low_cmp;
      hi = high_cmp;
      mn = speed_floor;
      mx = speed_ceiling;
      if (pct < mn) return ST_UNDER;
      if (pct > mx) return ST_ABOVE;
      if (mx == mn || hi < lo) val = lo;
      else val = lo + ((pct - mn) * (hi - lo)) / (mx - mn);
      if (ccw_side) begin
        cmp_a = '0;
        cmp_b = 16'(val);
      end else begin
        cmp_a = 16'(val);
        cmp_b = '0;
      end
      return ST_OK;
    endfunction

    // True when a move of this angle, started now, can be ended by a sample.
    function bit move_ends(int a);
      int unsigned dv;
      longint p;
      if (a == FULL_TURN) return 1'b1;
      if (a == -FULL_TURN) return 1'b0;
      dv = (dpp == 0) ? 1 : dpp;
      p = (a < 0 ? -a : a) / dv;
      if (a < 0) return (longint'(count) - p) >= 1;
      return (longint'(count) + p) <= 65534;
    endfunction

    function void take_command(logic [2:0] mode, logic [7:0] speed, logic dir,
                               logic signed [15:0] ang, logic [15:0] enc);
      drive_result_t r;
      epmd_status_t  st;
      bit            busy, done;
      int unsigned   dv, mag;
      longint        pulses, smp;
      st = ST_OK;
      busy = (phase != PH_IDLE);
      case (mode)
        MODE_SPEED: st = busy ? ST_BUSY : set_drive(speed, dir);
        MODE_STOP: begin
          if (busy) st = ST_BUSY;
          else begin
            cmp_a = '0;
            cmp_b = '0;
          end
        end
        MODE_MOVE: begin
          if (busy) st = ST_BUSY;
          else if (ang > max_ang) st = ST_ABOVE;
          else if (ang < min_ang) st = ST_UNDER;
          else if (ang != 0) begin
            angle_pending = ang;
            if (ang == FULL_TURN) begin
              target = 2 * longint'(dflt_count);
              ccw = 1'b0;
              void'(set_drive(SLOW_PERCENT, 1'b0));
              phase = PH_SLOW;
            end else if (ang == -FULL_TURN) begin
              target = 0;
              ccw = 1'b1;
              void'(set_drive(SLOW_PERCENT, 1'b1));
              phase = PH_SLOW;
            end else begin
              dv = (dpp == 0) ? 1 : dpp;
              mag = (ang < 0) ? -int'(ang) : int'(ang);
              pulses = mag / dv;
              ccw = (ang < 0);
              target = ccw ? longint'(count) - pulses : longint'(count) + pulses;
              void'(set_drive(KICK_PERCENT, ccw));
              phase = PH_KICK;
            end
          end
        end
        MODE_SAMPLE: begin
          if (phase == PH_SLOW) begin
            count = enc;
            smp = enc;
            done = ccw ? (smp < target) : (smp > target);
            if (done) begin
              cmp_a = '0;
              cmp_b = '0;
              angle_sum = angle_sum + angle_pending;
              phase = PH_IDLE;
            end
          end
        end
        MODE_TICK: begin
          if (phase == PH_KICK) begin
            void'(set_drive(SLOW_PERCENT, ccw));
            phase = PH_SLOW;
          end
        end
        MODE_INIT: begin
          if (busy) st = ST_BUSY;
          else begin
            low_cmp = scale_period(speed_floor);
            high_cmp = scale_period(speed_ceiling);
            angle_sum = init_ang;
            count = dflt_count;
          end
        end
        default: ;
      endcase
      r.cmp_a = cmp_a;
      r.cmp_b = cmp_b;
      r.status = st;
      r.moving = (phase != PH_IDLE);
      r.angle = angle_sum;
      r.count = count;
      expected_drives.push_back(r);
    endfunction

    function void report(string field, logic signed [31:0] want, logic signed [31:0] got);
      errors++;
      $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_result(drive_result_t got);
      drive_result_t want;
      if (expected_drives.size() == 0) begin
        errors++;
        $display("%0t ns: result item with none expected, actual a=%0d b=%0d status=%0d",
                 $time, got.cmp_a, got.cmp_b, got.status);
        return;
      end
      want = expected_drives.pop_front();
      if (got.cmp_a !== want.cmp_a) report("compare_a", want.cmp_a, got.cmp_a);
      if (got.cmp_b !== want.cmp_b) report("compare_b", want.cmp_b, got.cmp_b);
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.moving !== want.moving) report("moving", want.moving, got.moving);
      if (got.angle !== want.angle) report("shaft_angle", want.angle, got.angle);
      if (got.count !== want.count) report("current_count", want.count, got.count);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  epmd_in_if  req_ch();
  epmd_out_if res_ch();

  drive_tracker tracker = new();
  int send_idle;
  int recv_idle;
  int useful_items;

  encoder_position_motor_drive dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (req_ch),
    .result    (res_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    drive_result_t got;
    if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.cmp_a = res_ch.compare_a;
      got.cmp_b = res_ch.compare_b;
      got.status = epmd_status_t'(res_ch.status);
      got.moving = res_ch.moving;
      got.angle = res_ch.shaft_angle;
      got.count = res_ch.current_count;
      tracker.check_result(got);
    end
  end

  task automatic send(input logic [2:0] mode, input logic [7:0] speed, input logic dir,
                      input logic signed [15:0] ang, input logic [15:0] enc,
                      input bit counted = 1'b1);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.mode = mode;
    req_ch.speed = speed;
    req_ch.direction = dir;
    req_ch.move_angle = ang;
    req_ch.encoder_count = enc;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    tracker.take_command(mode, speed, dir, ang, enc);
    if (counted) useful_items++;
  endtask

  task automatic quiesce();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (tracker.expected_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(epmd_reg_t idx, int value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = 16'(value);
    @(posedge clk);
    tracker.write_reg(idx, 16'(value));
  endtask

  task automatic apply_settings(int mn, int mx, int per, int amin, int amax, int dpp,
                                int dflt, int ia);
    write_reg(REG_MIN_SPEED, mn);
    write_reg(REG_MAX_SPEED, mx);
    write_reg(REG_PERIOD_COUNT, per);
    write_reg(REG_MIN_ANGLE, amin);
    write_reg(REG_MAX_ANGLE, amax);
    write_reg(REG_DEG_PER_PULSE, dpp);
    write_reg(REG_DEFAULT_COUNT, dflt);
    write_reg(REG_INITIAL_ANGLE, ia);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic send_busy();
    case ($urandom_range(3))
      0: send(MODE_SPEED, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      1: send(MODE_STOP, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      2: send(MODE_MOVE, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      default: send(MODE_INIT, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    endcase
  endtask

  task automatic send_speed();
    int s;
    if (tracker.speed_floor <= tracker.speed_ceiling && $urandom_range(3) != 0)
      s = $urandom_range(tracker.speed_ceiling, tracker.speed_floor);
    else
      s = $urandom_range(255);
    send(MODE_SPEED, 8'(s), 1'($urandom), 16'($urandom), 16'($urandom));
  endtask

  function automatic int pick_angle();
    int lo, hi, a;
    lo = tracker.min_ang;
    hi = tracker.max_ang;
    if (lo > hi) return int'($urandom_range(65535)) - 32768;
    if ($urandom_range(1) == 1) begin
      if (lo < -400) lo = -400;
      if (hi > 400) hi = 400;
      if (lo > hi) begin
        lo = tracker.min_ang;
        hi = tracker.max_ang;
      end
    end
    a = lo + int'($urandom_range(hi - lo));
    if ($urandom_range(9) == 0 || a == -FULL_TURN) a = FULL_TURN;
    if (a == FULL_TURN || a == 0) return a;
    if (!tracker.move_ends(a)) a = -a;
    if (a > 32767 || !tracker.move_ends(a)) a = 0;
    return a;
  endfunction

  task automatic send_noise();
    logic [2:0]         mode;
    logic signed [15:0] ang;
    mode = 3'($urandom);
    ang = (mode == MODE_MOVE) ? 16'(pick_angle()) : 16'($urandom);
    send(mode, 8'($urandom), 1'($urandom), ang, 16'($urandom), 1'b0);
  endtask

  task automatic run_move();
    int t;
    send(MODE_MOVE, 8'($urandom), 1'($urandom), 16'(pick_angle()), 16'($urandom));
    if (tracker.phase == PH_IDLE) return;
    if (tracker.phase == PH_KICK) begin
      if ($urandom_range(2) == 0)
        send(MODE_SAMPLE, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      if ($urandom_range(3) == 0) send_busy();
      send(MODE_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    end
    t = int'(tracker.target);
    repeat ($urandom_range(4)) begin
      case ($urandom_range(5))
        0: send_busy();
        1: send(MODE_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        default: begin
          if (tracker.ccw)
            send(MODE_SAMPLE, 8'($urandom), 1'($urandom), 16'($urandom),
                 16'($urandom_range(65535, t)));
          else
            send(MODE_SAMPLE, 8'($urandom), 1'($urandom), 16'($urandom),
                 16'($urandom_range(t, 0)));
        end
      endcase
    end
    if (tracker.ccw)
      send(MODE_SAMPLE, 8'($urandom), 1'($urandom), 16'($urandom),
           16'($urandom_range(t - 1, 0)));
    else
      send(MODE_SAMPLE, 8'($urandom), 1'($urandom), 16'($urandom),
           16'($urandom_range(65535, t + 1)));
  endtask

  task automatic random_block(int quota);
    int stop_at, pick;
    stop_at = useful_items + quota;
    send(MODE_INIT, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    while (useful_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) run_move();
      else if (pick < 65) send_speed();
      else if (pick < 72) send(MODE_STOP, 8'($urandom), 1'($urandom), 16'($urandom),
                               16'($urandom));
      else if (pick < 78) send(MODE_INIT, 8'($urandom), 1'($urandom), 16'($urandom),
                               16'($urandom));
      else send_noise();
    end
  endtask

  task automatic directed_items();
    send(MODE_SPEED, 8'd50, 1'b0, '0, '0);
    send(MODE_INIT, '0, 1'b0, '0, '0);
    send(MODE_SPEED, 8'd0, 1'b0, '0, '0);
    send(MODE_SPEED, 8'd100, 1'b1, '0, '0);
    send(MODE_SPEED, 8'd101, 1'b0, '0, '0);
    send(MODE_SPEED, 8'd255, 1'b1, '0, '0);
    send(MODE_STOP, '0, 1'b0, '0, '0);
    send(MODE_SPARE_A, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    send(MODE_MOVE, '0, 1'b0, 16'sd0, '0);
    send(MODE_MOVE, '0, 1'b0, 16'sd361, '0);
    send(MODE_MOVE, '0, 1'b0, -16'sd361, '0);
    send(MODE_MOVE, '0, 1'b0, 16'sd32767, '0);
    send(MODE_MOVE, '0, 1'b0, -16'sd32768, '0);
    send(MODE_MOVE, '0, 1'b0, 16'sd10, '0);
    send(MODE_SAMPLE, '0, 1'b0, '0, 16'd65535);
    send(MODE_SPEED, 8'd60, 1'b0, '0, '0);
    send(MODE_TICK, '0, 1'b0, '0, '0);
    send(MODE_SAMPLE, '0, 1'b0, '0, 16'd16384);
    send(MODE_SAMPLE, '0, 1'b0, '0, 16'd16395);
    send(MODE_MOVE, '0, 1'b0, FULL_TURN, '0);
    send(MODE_INIT, '0, 1'b0, '0, '0);
    send(MODE_SAMPLE, '0, 1'b0, '0, 16'd0);
    send(MODE_SAMPLE, '0, 1'b0, '0, 16'd65535);
    send(MODE_MOVE, '0, 1'b0, -16'sd20, '0);
    send(MODE_TICK, '0, 1'b0, '0, '0);
    send(MODE_SAMPLE, '0, 1'b0, '0, 16'd65535);
    send(MODE_SAMPLE, '0, 1'b0, '0, 16'd0);
  endtask

  initial begin
    int mn, dflt;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_MIN_SPEED;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_SPEED;
    req_ch.speed = '0;
    req_ch.direction = 1'b0;
    req_ch.move_angle = '0;
    req_ch.encoder_count = '0;
    send_idle = 0;
    recv_idle = 0;
    useful_items = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int seg = 0; seg < 9; seg++) begin
      if (seg < 3) begin
        send_idle = 34;
        recv_idle = 82;
      end else if (seg < 6) begin
        send_idle = 82;
        recv_idle = 34;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      quiesce();
      case (seg)
        0: apply_settings(0, 100, 65535, -360, 360, 1, 16384, 0);
        1: apply_settings(20, 80, 1000, -1000, 1000, 3, 500, 32767);
        2: apply_settings(50, 50, 0, -32768, 32767, 360, 32767, -32768);
        3: apply_settings(0, 0, 65535, 100, -100, 0, 0, 360);
        5: apply_settings(100, 0, 12345, -32768, 32767, 2, 32767, -1);
        default: begin
          mn = $urandom_range(100);
          apply_settings(mn, $urandom_range(100, mn), $urandom_range(65535),
                         -int'($urandom_range(2000)), $urandom_range(2000),
                         $urandom_range(8, 1), $urandom_range(32767),
                         $urandom_range(65535));
        end
      endcase
      if (seg == 0) directed_items();
      random_block(45);
    end

    // A move that can never end: either a full counter-clockwise turn aiming
    // at zero, or a counter-clockwise move whose target lies below zero.
    quiesce();
    dflt = $urandom_range(200, 1);
    apply_settings(0, 100, 65535, -32768, 32767, 1, dflt, 0);
    send(MODE_INIT, '0, 1'b0, '0, '0);
    if ($urandom_range(1) == 1)
      send(MODE_MOVE, '0, 1'b0, -FULL_TURN, '0);
    else
      send(MODE_MOVE, '0, 1'b0, 16'(-(dflt + 1 + int'($urandom_range(50)))), '0);
    send(MODE_TICK, '0, 1'b0, '0, '0);
    send(MODE_SAMPLE, '0, 1'b0, '0, 16'd0);
    send(MODE_SAMPLE, '0, 1'b0, '0, 16'd65535);
    send(MODE_SPEED, 8'd50, 1'b0, '0, '0);
    send(MODE_STOP, '0, 1'b0, '0, '0);
    send(MODE_INIT, '0, 1'b0, '0, '0);

    quiesce();
    repeat (80) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
rtl/epmd_pkg.sv
rtl/epmd_ifs.sv
rtl/epmd_div.sv
rtl/epmd_datapath.sv
rtl/epmd_ctrl.sv
rtl/encoder_position_motor_drive.sv
bench/testbench.sv
